FILE: hw/rtl/lpkt_pkg.sv
// Shared constants, codes and types of the linear probing key table.
`default_nettype none
package lpkt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int MULT_W      = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SUM_W       = $clog2(KEY_BYTES * 255 + 1);
  localparam int PROD_W      = SUM_W + MULT_W;
  localparam int CNT_W       = SLOT_W + 1;

  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(31);

  // Only the low KEY_BYTES bytes of a key take part in anything.
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // One classified item on its way from the front end to the engine.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
  } item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lpkt_req_if.sv
// Request channel: operation and key.
`default_nettype none
interface lpkt_req_if;
  import lpkt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lpkt_rsp_if.sv
// Response channel: status and slot.
`default_nettype none
interface lpkt_rsp_if;
  import lpkt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lpkt_cfg_if.sv
// Configuration write channel: hash multiplier.
`default_nettype none
interface lpkt_cfg_if;
  import lpkt_pkg::*;
  logic              valid;
  logic              ready;
  logic [MULT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/linear_probe_key_table.sv
// Top level of the linear probing key table.
`default_nettype none
// Key table of 1024 slots with open addressing and linear probing. Each request
// (insert, search, remove) is hashed in the front end (byte sum times
// hash_multiplier, low slot bits) and queued; the engine then probes one slot per
// cycle through the single read port of the slot RAM, starting at the home slot. A
// scan ends at a hit or after all 1024 slots have been read, so an insert of a new
// key or a miss reads every slot. Items are handled one at a time in the engine
// while the front end and a two-entry queue keep taking new ones. After reset the
// engine runs a clearing pass over all 1024 slots of the slot RAM before it takes
// the first item; configuration writes are accepted throughout.
module linear_probe_key_table_core
  import lpkt_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  lpkt_req_if.sink   req,
  lpkt_rsp_if.source rsp,
  lpkt_cfg_if.sink   cfg
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  lpkt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  lpkt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  lpkt_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/lpkt_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module lpkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lpkt_front.sv
// Front end: takes items, masks the key, hashes it to a home slot, holds the multiplier.
`default_nettype none
module lpkt_front
  import lpkt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  lpkt_req_if.sink   req,
  lpkt_cfg_if.sink   cfg,
  output logic       push_valid,
  output item_t      push_item,
  input  wire logic  push_ready
);

  logic [MULT_W-1:0] hash_multiplier;
  logic              stg_valid;
  logic [OP_W-1:0]   stg_op;
  logic [KEY_W-1:0]  stg_key;
  logic [SUM_W-1:0]  stg_sum;

  logic [KEY_W-1:0]  key_masked;
  logic [SUM_W-1:0]  byte_sum;
  logic [PROD_W-1:0] product;
  logic              take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= MULT_RESET;
    end else if (cfg.valid) begin
      hash_multiplier <= cfg.data;
    end
  end

  assign key_masked = req.key & KEY_MASK;

  always_comb begin
    byte_sum = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      byte_sum = byte_sum + SUM_W'(key_masked[8*b +: 8]);
    end
  end

  // Stage register drains into the queue; refill in the same cycle.
  assign req.ready = !stg_valid || push_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (take) begin
      stg_valid <= 1'b1;
    end else if (push_ready) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_op  <= req.operation;
      stg_key <= key_masked;
      stg_sum <= byte_sum;
    end
  end

  // Depth is a power of two, so the modulo is the low bits of the product.
  assign product = PROD_W'(stg_sum) * PROD_W'(hash_multiplier);

  assign push_valid = stg_valid;
  assign push_item  = '{op: stg_op, key: stg_key, home: product[SLOT_W-1:0]};

endmodule
`default_nettype wire

FILE: hw/rtl/lpkt_queue.sv
// Two-entry queue of hashed items between front end and engine.
`default_nettype none
module lpkt_queue
  import lpkt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  input  wire item_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output item_t      pop_item,
  input  wire logic  pop
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

FILE: hw/rtl/lpkt_engine.sv
// Back end: clearing pass, linear probe scan over the slot RAM, update and result register.
`default_nettype none
module lpkt_engine
  import lpkt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  lpkt_rsp_if.source rsp
);

  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(TABLE_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [SLOT_W-1:0]   clr_addr;
  logic [OP_W-1:0]     cur_op;
  logic [KEY_W-1:0]    cur_key;
  logic [SLOT_W-1:0]   probe_addr;
  logic [CNT_W-1:0]    probe_cnt;
  logic                chk_valid;
  logic [SLOT_W-1:0]   chk_addr;
  logic                found;
  logic [SLOT_W-1:0]   found_slot;
  logic                free_seen;
  logic [SLOT_W-1:0]   free_slot;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [SLOT_W-1:0]   rsp_slot;

  // RAM word: used flag on top of the key.
  logic                ram_wr_en;
  logic [SLOT_W-1:0]   ram_wr_addr;
  logic [KEY_W:0]      ram_wr_data;
  logic                ram_rd_en;
  logic [KEY_W:0]      ram_rd_data;

  logic                hit;
  logic                scan_end;
  logic                out_free;
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_write;
  logic                res_used;

  lpkt_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (probe_addr),
    .rd_data (ram_rd_data)
  );

  assign hit      = chk_valid && ram_rd_data[KEY_W] && (ram_rd_data[KEY_W-1:0] == cur_key);
  assign scan_end = hit || (!chk_valid && (probe_cnt == CNT_FULL));
  assign out_free = !rsp_valid || rsp.ready;

  // Outcome of a finished scan.
  always_comb begin
    res_status = ST_ABSENT;
    res_slot   = '0;
    res_write  = 1'b0;
    res_used   = 1'b0;
    priority case (1'b1)
      found: begin
        res_status = ST_FOUND;
        res_slot   = found_slot;
        res_write  = (cur_op == OP_REMOVE);
      end
      (cur_op == OP_INSERT) && free_seen: begin
        res_status = ST_INSERTED;
        res_slot   = free_slot;
        res_write  = 1'b1;
        res_used   = 1'b1;
      end
      (cur_op == OP_INSERT): begin
        res_status = ST_FULL;
      end
      default: begin
        res_status = ST_ABSENT;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == SLOT_LAST) state_next = S_IDLE;
      S_IDLE:   if (q_valid) state_next = S_SCAN;
      S_SCAN:   if (scan_end) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_addr;
    ram_wr_data = '0;
    res_load    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      S_IDLE: begin
        q_pop = q_valid;
      end
      S_SCAN: begin
        ram_rd_en = !hit && (probe_cnt != CNT_FULL);
      end
      S_FINISH: begin
        res_load    = out_free;
        ram_wr_en   = out_free && res_write;
        ram_wr_addr = res_slot;
        ram_wr_data = {res_used, cur_key};
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
      found     <= 1'b0;
      free_seen <= 1'b0;
    end else if (q_pop) begin
      cur_op     <= q_item.op;
      cur_key    <= q_item.key;
      probe_addr <= q_item.home;
      probe_cnt  <= '0;
      chk_valid  <= 1'b0;
      found      <= 1'b0;
      free_seen  <= 1'b0;
    end else if (state == S_SCAN) begin
      chk_valid <= ram_rd_en;
      if (ram_rd_en) begin
        chk_addr   <= probe_addr;
        probe_addr <= (probe_addr == SLOT_LAST) ? '0 : probe_addr + 1'b1;
        probe_cnt  <= probe_cnt + 1'b1;
      end
      if (hit) begin
        found      <= 1'b1;
        found_slot <= chk_addr;
      end else if (chk_valid && !ram_rd_data[KEY_W] && !free_seen) begin
        free_seen <= 1'b1;
        free_slot <= chk_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp_status <= res_status;
      rsp_slot   <= res_slot;
    end
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.slot   = rsp_slot;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_wr_en)
    else $error("slot RAM written during scan");

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_pop)
    else $error("item taken during clearing pass");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!rsp_valid || rsp.ready))
    else $error("result register overwritten");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && chk_valid |=> probe_cnt <= CNT_FULL)
    else $error("probe count ran past table depth");

endmodule
`default_nettype wire
